[hdl/assert_macros.svh]
// Shared assertion macros for the ring buffer checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ORF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds through reset.
`define ORF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/orf_pkg.sv]
package orf_pkg;

  // command codes
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_PEEK  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register index (byte address bit 2)
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  localparam logic [12:0] SLOTS_RESET = 13'd4096;
  localparam logic [16:0] HELD_MAX    = 17'h1FFFF;

  typedef struct packed {
    logic        valid;
    logic [63:0] data;
  } slot_t;

  // per-beat result data except the record itself
  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] fill_level;
    logic        is_full;
    logic        is_empty;
    logic [31:0] records_written;
    logic [16:0] held_bytes;
    logic        dropped_oldest;
    logic        use_mem;
  } meta_t;

endpackage

[hdl/orf_mem.sv]
module orf_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  orf_pkg::slot_t  wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output orf_pkg::slot_t  rdata
);
  import orf_pkg::*;

  slot_t mem [DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/orf_ctrl.sv]
module orf_ctrl #(
  parameter int SLOT_COUNT   = 4096,
  parameter int RECORD_BYTES = 8,
  parameter int AW           = 12,
  parameter int SW           = 13
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [12:0]     cfg_val,
  input  logic            go,
  input  logic [1:0]      cmd,
  input  logic [63:0]     record_in,
  input  logic [15:0]     extra_bytes,
  input  logic [11:0]     slot_index,
  output logic            busy,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output orf_pkg::slot_t  mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  output orf_pkg::meta_t  meta
);
  import orf_pkg::*;

  localparam int SIZE_RST = (SLOT_COUNT < 4096) ? SLOT_COUNT : 4096;
  localparam int BW = ((SW + 4 > 16) ? SW + 4 : 16) + 1;
  localparam int CW = (SW > 12) ? SW : 12;

  logic [SW-1:0] size_r,  size_nxt;
  logic [AW-1:0] rp_r,    rp_nxt;
  logic [AW-1:0] wp_r,    wp_nxt;
  logic [AW-1:0] cnt_r,   cnt_nxt;
  logic [31:0]   pc_r,    pc_nxt;
  logic [16:0]   held_r,  held_nxt;
  logic          busy_r,  busy_nxt;
  logic [AW-1:0] swp_r,   swp_nxt;

  logic          full, empty, drop;
  logic [AW-1:0] fill_ad;
  logic [BW-1:0] bytes;
  logic [1:0]    status;
  logic          use_mem;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [SW-1:0] sz);
    logic [SW-1:0] q;
    q = SW'(p) + SW'(1);
    return (q >= sz) ? '0 : AW'(q);
  endfunction

  assign full  = (SW'(cnt_r) == (size_r - SW'(1)));
  assign empty = (cnt_r == '0);
  assign drop  = go && (cmd == CMD_PUT) && full;

  assign fill_ad = full ? (cnt_r - AW'(1)) : cnt_r;
  assign bytes   = BW'(fill_ad) * BW'(RECORD_BYTES) + BW'(extra_bytes);

  always_comb begin
    size_nxt = size_r;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    cnt_nxt  = cnt_r;
    pc_nxt   = pc_r;
    held_nxt = held_r;
    busy_nxt = busy_r;
    swp_nxt  = swp_r;
    status   = ST_OK;
    use_mem  = 1'b0;
    mem_re   = 1'b0;
    mem_raddr = rp_r;

    if (busy_r) begin
      swp_nxt = swp_r + AW'(1);
      if (swp_r == AW'(SLOT_COUNT - 1)) begin
        busy_nxt = 1'b0;
      end
    end

    if (cfg_we) begin
      if (cfg_val < 13'd2) begin
        size_nxt = SW'(2);
      end else if (32'(cfg_val) > 32'(SLOT_COUNT)) begin
        size_nxt = SW'(SLOT_COUNT);
      end else begin
        size_nxt = SW'(cfg_val);
      end
      rp_nxt  = '0;
      wp_nxt  = '0;
      cnt_nxt = '0;
    end else if (go) begin
      case (cmd)
        CMD_PUT: begin
          if (full) begin
            rp_nxt = adv(rp_r, size_r);
          end
          cnt_nxt  = fill_ad + AW'(1);
          wp_nxt   = adv(wp_r, size_r);
          pc_nxt   = pc_r + 32'd1;
          held_nxt = (bytes > BW'(HELD_MAX)) ? HELD_MAX : 17'(bytes);
        end
        CMD_GET: begin
          if (empty) begin
            status = ST_EMPTY;
          end else begin
            use_mem = 1'b1;
            mem_re  = 1'b1;
            rp_nxt  = adv(rp_r, size_r);
            cnt_nxt = cnt_r - AW'(1);
          end
        end
        CMD_PEEK: begin
          mem_raddr = AW'(slot_index);
          if (empty) begin
            status = ST_EMPTY;
          end else if (CW'(slot_index) >= CW'(size_r)) begin
            status = ST_RANGE;
          end else begin
            use_mem = 1'b1;
            mem_re  = 1'b1;
          end
        end
        default: begin
          // clear: empty the ring, zero the counters and sweep the valid flags
          rp_nxt   = '0;
          wp_nxt   = '0;
          cnt_nxt  = '0;
          pc_nxt   = '0;
          held_nxt = '0;
          busy_nxt = 1'b1;
          swp_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SW'(SIZE_RST);
      rp_r   <= '0;
      wp_r   <= '0;
      cnt_r  <= '0;
      pc_r   <= '0;
      held_r <= '0;
      busy_r <= 1'b1;
      swp_r  <= '0;
    end else begin
      size_r <= size_nxt;
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      cnt_r  <= cnt_nxt;
      pc_r   <= pc_nxt;
      held_r <= held_nxt;
      busy_r <= busy_nxt;
      swp_r  <= swp_nxt;
    end
  end

  assign busy = busy_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = '{valid: 1'b1, data: record_in};
    if (busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = swp_r;
      mem_wdata = '{valid: 1'b0, data: 64'd0};
    end else if (go && (cmd == CMD_PUT)) begin
      mem_we = 1'b1;
    end
  end

  assign meta.status          = status;
  assign meta.fill_level      = 12'(cnt_nxt);
  assign meta.is_full         = (SW'(cnt_nxt) == (size_r - SW'(1)));
  assign meta.is_empty        = (cnt_nxt == '0);
  assign meta.records_written = pc_nxt;
  assign meta.held_bytes      = held_nxt;
  assign meta.dropped_oldest  = drop;
  assign meta.use_mem         = use_mem;

endmodule

[hdl/overwriting_ring_fifo.sv]
// Overwriting ring buffer of 64-bit records.
// Input channel (in_valid / in_stall): one command per beat - put, get oldest,
// peek an absolute slot, or clear. A beat is taken when in_valid is high and
// in_stall is low. Result channel (out_valid / out_stall): exactly one result
// beat per command, in order, with record, status, fill level, full/empty
// flags, put count, held-byte figure and the drop flag.
// Path: a taken command's figures and slot memory read are registered in the
// read stage on the accepting edge, then pass on to the output register.
// Throughput: one command per cycle while in_stall is low; pointers update in
// the cycle a command is taken; the slot memory sees at most one access each.
// A put on a full ring drops the oldest record instead of stalling.
// A stalled result holds on the output; one more result waits in the read
// stage behind it, after which in_stall rises until the receiver drains.
// Reset and clear: a sweep walks the slot memory one entry per cycle, over all
// SLOT_COUNT entries, to mark all slots invalid; in_stall stays high during
// the sweep, while register writes are still taken.
// The APB register slots_in_use (address 0) sets the ring length; a write
// empties the ring but keeps slot contents and counters.
module overwriting_ring_fifo #(
  parameter int SLOT_COUNT   = 4096,
  parameter int RECORD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_record_in,
  input  logic [15:0] in_extra_bytes,
  input  logic [11:0] in_slot_index,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_record_out,
  output logic [1:0]  out_status,
  output logic [11:0] out_fill_level,
  output logic        out_is_full,
  output logic        out_is_empty,
  output logic [31:0] out_records_written,
  output logic [16:0] out_held_bytes,
  output logic        out_dropped_oldest
);
  import orf_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int SW = $clog2(SLOT_COUNT + 1);

  // register port
  logic [12:0] slots_r;
  logic        cfg_we;

  // control / memory hookup
  logic          busy;
  logic          go;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  slot_t         mem_wdata, mem_rdata;
  meta_t         meta;

  // read stage and output register
  logic          p_valid_r, p_valid_nxt;
  meta_t         p_meta_r;
  logic          move;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_record_r;
  meta_t         out_meta_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IN_USE);
  assign prdata = (paddr[2] == REG_SLOTS_IN_USE) ? {19'd0, slots_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
    end else if (cfg_we) begin
      slots_r <= pwdata[12:0];
    end
  end

  // advance the read stage into the output register when it is free or taken
  assign move     = p_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = busy || (p_valid_r && !move);
  assign go       = in_valid && !in_stall;

  orf_ctrl #(
    .SLOT_COUNT   (SLOT_COUNT),
    .RECORD_BYTES (RECORD_BYTES),
    .AW           (AW),
    .SW           (SW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_val     (pwdata[12:0]),
    .go          (go),
    .cmd         (in_command),
    .record_in   (in_record_in),
    .extra_bytes (in_extra_bytes),
    .slot_index  (in_slot_index),
    .busy        (busy),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .meta        (meta)
  );

  orf_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (go) begin
      p_valid_nxt = 1'b1;
    end else if (move) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: capture the command's figures, then merge in the slot read
  always_ff @(posedge clk) begin
    if (go) begin
      p_meta_r <= meta;
    end
    if (move) begin
      out_meta_r   <= p_meta_r;
      // an invalid slot reads as zero
      out_record_r <= (p_meta_r.use_mem && mem_rdata.valid) ? mem_rdata.data : 64'd0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_out      = out_record_r;
  assign out_status          = out_meta_r.status;
  assign out_fill_level      = out_meta_r.fill_level;
  assign out_is_full         = out_meta_r.is_full;
  assign out_is_empty        = out_meta_r.is_empty;
  assign out_records_written = out_meta_r.records_written;
  assign out_held_bytes      = out_meta_r.held_bytes;
  assign out_dropped_oldest  = out_meta_r.dropped_oldest;

endmodule

[hdl/orf_checker.sv]
`include "assert_macros.svh"

module orf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_record_out,
  input logic [1:0]  out_status,
  input logic [11:0] out_fill_level,
  input logic        out_is_full,
  input logic        out_is_empty,
  input logic        out_dropped_oldest
);
  import orf_pkg::*;

  `ORF_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable({out_record_out, out_status, out_fill_level}), "stalled result changed")
  `ORF_ASSERT(a_full_empty, clk, rst_n, out_valid |-> !(out_is_full && out_is_empty), "full and empty at once")
  `ORF_ASSERT(a_fail_zero, clk, rst_n, out_valid && (out_status != ST_OK) |-> (out_record_out == 64'd0), "failed command returned a record")
  `ORF_ASSERT(a_drop_full, clk, rst_n, out_valid && out_dropped_oldest |-> out_is_full, "drop did not leave the ring full")
  `ORF_ASSERT(a_empty_level, clk, rst_n, out_valid && out_is_empty |-> (out_fill_level == 12'd0), "empty ring with nonzero level")

endmodule

bind overwriting_ring_fifo orf_checker u_orf_checker (.*);

[tb/tb_overwriting_ring_fifo.sv]
`timescale 1ns / 1ps

module tb_overwriting_ring_fifo;
  import orf_pkg::*;

  localparam int SLOT_COUNT   = 4096;
  localparam int RECORD_BYTES = 8;
  // Longest legal quiet stretch is one clear sweep over all SLOT_COUNT slots
  // plus a long receiver stall; allow several times that.
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 1225;
  localparam logic [2:0] ADDR_SLOTS_IN_USE = {REG_SLOTS_IN_USE, 2'b00};

  // Ring lengths for the random phases: tiny rings to hit wrap and drop,
  // the register extremes (0, 1, 8191) and both sides of SLOT_COUNT.
  localparam int PHASE_COUNT = 14;
  localparam logic [12:0] PHASE_LENS [PHASE_COUNT] = '{
    13'd3, 13'd2, 13'd5, 13'd4096, 13'd1, 13'd8, 13'd16,
    13'd8191, 13'd7, 13'd0, 13'd33, 13'd4097, 13'd3, 13'd12
  };

  typedef struct packed {
    logic [63:0] record;
    logic [1:0]  status;
    logic [11:0] fill;
    logic        full;
    logic        empty;
    logic [31:0] written;
    logic [16:0] held;
    logic        dropped;
  } ring_beat_t;

  // Shadow ring: mirrors pointers, slot contents and counters, and keeps the
  // result beats still owed by the block, oldest first.
  class ring_tracker;
    logic [63:0] slot_data [SLOT_COUNT];
    bit          slot_live [SLOT_COUNT];
    bit          slot_touched [SLOT_COUNT];
    logic [11:0] rd_ptr;
    logic [11:0] wr_ptr;
    logic [31:0] put_total;
    logic [16:0] held_latch;
    logic [12:0] len_reg;
    ring_beat_t  expected_beats [$];
    int mismatches;
    int commands;
    int drops;
    int empty_replies;
    int range_replies;
    int dead_peeks;
    int clears;

    function new();
      len_reg = SLOTS_RESET;
      rd_ptr = '0;
      wr_ptr = '0;
      put_total = '0;
      held_latch = '0;
      mismatches = 0;
      commands = 0;
      drops = 0;
      empty_replies = 0;
      range_replies = 0;
      dead_peeks = 0;
      clears = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_data[i] = '0;
        slot_live[i] = 1'b0;
        slot_touched[i] = 1'b0;
      end
    endfunction

    function logic [12:0] ring_len();
      if (len_reg < 13'd2) return 13'd2;
      if (len_reg > SLOT_COUNT) return 13'(SLOT_COUNT);
      return len_reg;
    endfunction

    function logic [11:0] bump(logic [11:0] p);
      logic [12:0] nxt;
      nxt = {1'b0, p} + 13'd1;
      return (nxt >= ring_len()) ? 12'd0 : nxt[11:0];
    endfunction

    function logic [11:0] level();
      if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
      return 12'(ring_len() + wr_ptr - rd_ptr);
    endfunction

    function bit ring_empty();
      return rd_ptr == wr_ptr;
    endfunction

    // A register write empties the ring but keeps data, valid bits and counters.
    function void set_length(logic [12:0] value);
      len_reg = value;
      rd_ptr = '0;
      wr_ptr = '0;
    endfunction

    // True when a peek would fetch a store entry that no put ever filled.
    function bit peek_hits_unwritten(logic [11:0] idx);
      return !ring_empty() && (idx < ring_len()) && !slot_touched[idx];
    endfunction

    function void take_command(logic [1:0] cmd, logic [63:0] rec,
                               logic [15:0] extra, logic [11:0] idx);
      ring_beat_t  b;
      int unsigned bytes;
      b = '0;
      commands++;
      case (cmd)
        CMD_PUT: begin
          // Full ring: drop the oldest first, then size the held figure.
          if (bump(wr_ptr) == rd_ptr) begin
            rd_ptr = bump(rd_ptr);
            b.dropped = 1'b1;
            drops++;
          end
          bytes = level() * RECORD_BYTES + extra;
          held_latch = (bytes > HELD_MAX) ? HELD_MAX : 17'(bytes);
          slot_data[wr_ptr] = rec;
          slot_live[wr_ptr] = 1'b1;
          slot_touched[wr_ptr] = 1'b1;
          wr_ptr = bump(wr_ptr);
          put_total++;
        end
        CMD_GET: begin
          if (ring_empty()) begin
            b.status = ST_EMPTY;
            empty_replies++;
          end else begin
            b.record = slot_live[rd_ptr] ? slot_data[rd_ptr] : 64'd0;
            rd_ptr = bump(rd_ptr);
          end
        end
        CMD_PEEK: begin
          // Empty wins over range.
          if (ring_empty()) begin
            b.status = ST_EMPTY;
            empty_replies++;
          end else if (idx >= ring_len()) begin
            b.status = ST_RANGE;
            range_replies++;
          end else begin
            if (!slot_live[idx]) dead_peeks++;
            b.record = slot_live[idx] ? slot_data[idx] : 64'd0;
          end
        end
        CMD_CLEAR: begin
          rd_ptr = '0;
          wr_ptr = '0;
          put_total = '0;
          held_latch = '0;
          for (int i = 0; i < SLOT_COUNT; i++) slot_live[i] = 1'b0;
          clears++;
        end
      endcase
      b.fill = level();
      b.full = bump(wr_ptr) == rd_ptr;
      b.empty = ring_empty();
      b.written = put_total;
      b.held = held_latch;
      expected_beats.push_back(b);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void match_result(ring_beat_t got);
      ring_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result beat with nothing outstanding, record %0h",
                   $time, got.record);
        return;
      end
      want = expected_beats.pop_front();
      if (got.record !== want.record)   flag("record_out", want.record, got.record);
      if (got.status !== want.status)   flag("status", want.status, got.status);
      if (got.fill !== want.fill)       flag("fill_level", want.fill, got.fill);
      if (got.full !== want.full)       flag("is_full", want.full, got.full);
      if (got.empty !== want.empty)     flag("is_empty", want.empty, got.empty);
      if (got.written !== want.written) flag("records_written", want.written, got.written);
      if (got.held !== want.held)       flag("held_bytes", want.held, got.held);
      if (got.dropped !== want.dropped) flag("dropped_oldest", want.dropped, got.dropped);
    endfunction

    function void settle();
      if (expected_beats.size() != 0) begin
        mismatches++;
        $display("%0d result beats never arrived", expected_beats.size());
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = CMD_PUT;
  logic [63:0] in_record_in = '0;
  logic [15:0] in_extra_bytes = '0;
  logic [11:0] in_slot_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_record_out;
  logic [1:0]  out_status;
  logic [11:0] out_fill_level;
  logic        out_is_full;
  logic        out_is_empty;
  logic [31:0] out_records_written;
  logic [16:0] out_held_bytes;
  logic        out_dropped_oldest;

  ring_tracker tracker;
  bit tx_jitter = 1'b0;
  bit rx_jitter = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  overwriting_ring_fifo u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_record_in        (in_record_in),
    .in_extra_bytes      (in_extra_bytes),
    .in_slot_index       (in_slot_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_out      (out_record_out),
    .out_status          (out_status),
    .out_fill_level      (out_fill_level),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty),
    .out_records_written (out_records_written),
    .out_held_bytes      (out_held_bytes),
    .out_dropped_oldest  (out_dropped_oldest)
  );

  // Receiver: stall in random bursts, now and then a long one. With rx_jitter
  // off, take every result beat as it comes.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (rx_jitter && $urandom_range(0, 99) < 30) begin
      out_stall = 1'b1;
      stall_left = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 2);
    end else begin
      out_stall = 1'b0;
    end
  end

  // Check every result beat the moment it is taken.
  always @(posedge clk) begin : result_monitor
    ring_beat_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.record  = out_record_out;
      seen.status  = out_status;
      seen.fill    = out_fill_level;
      seen.full    = out_is_full;
      seen.empty   = out_is_empty;
      seen.written = out_records_written;
      seen.held    = out_held_bytes;
      seen.dropped = out_dropped_oldest;
      tracker.match_result(seen);
    end
  end

  // Watchdog: any beat on either channel or a register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Sender gap after a beat: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (!tx_jitter) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one command beat, hold it until taken, then log it in the shadow ring.
  task automatic send_command(input logic [1:0] cmd, input logic [63:0] rec,
                              input logic [15:0] extra, input logic [11:0] idx);
    int gap;
    @(negedge clk);
    // Steer peeks away from store entries that were never written.
    if (cmd == CMD_PEEK && tracker.peek_hits_unwritten(idx)) idx = tracker.rd_ptr;
    in_valid       = 1'b1;
    in_command     = cmd;
    in_record_in   = rec;
    in_extra_bytes = extra;
    in_slot_index  = idx;
    do @(posedge clk); while (in_stall);
    tracker.take_command(cmd, rec, extra, idx);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result beat is back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.expected_beats.size() != 0) @(posedge clk);
  endtask

  // Reprogram the ring length over APB; only done with the ring idle.
  task automatic write_ring_length(input logic [12:0] value);
    wait_drained();
    repeat (2) @(posedge clk);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_SLOTS_IN_USE;
    pwdata  = {19'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_length(value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Random beat: puts outweigh gets so small rings fill and wrap; clears are
  // rare since each one costs a full valid-bit sweep.
  task automatic send_random_item();
    logic [1:0]  cmd;
    logic [11:0] idx;
    logic [15:0] extra;
    logic [12:0] len;
    int r;
    len = tracker.ring_len();
    r = $urandom_range(0, 199);
    if (r < 2)        cmd = CMD_CLEAR;
    else if (r < 92)  cmd = CMD_PUT;
    else if (r < 146) cmd = CMD_GET;
    else              cmd = CMD_PEEK;
    case ($urandom_range(0, 3))
      0, 1: idx = 12'($urandom_range(0, len - 1));
      2:    idx = 12'($urandom);
      default: begin
        // Hit the edge of the ring: last slot or first one past it.
        if (len < SLOT_COUNT && $urandom_range(0, 1) == 1) idx = len[11:0];
        else idx = 12'(len - 1);
      end
    endcase
    case ($urandom_range(0, 9))
      0:       extra = 16'd0;
      1:       extra = 16'hFFFF;
      default: extra = 16'($urandom);
    endcase
    send_command(cmd, {$urandom, $urandom}, extra, idx);
  endtask

  initial begin
    int sent;
    int phase;
    int quota;
    logic [12:0] len_val;
    tracker = new();
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, back to back with no idling. Four slots hold three records.
    write_ring_length(13'd4);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);        // get on empty ring
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd0);        // peek on empty ring
    send_command(CMD_PUT,  '1, 16'hFFFF, 12'hFFF);
    send_command(CMD_PUT,  64'h0, 16'h0, 12'd0);
    send_command(CMD_PUT,  64'hA5A5_A5A5_A5A5_A5A5, 16'h0001, 12'd0);
    send_command(CMD_PUT,  64'h5A5A_5A5A_5A5A_5A5A, 16'hFFFF, 12'd0);  // drop oldest
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd0);
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd4);        // first slot past the ring
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'hFFF);      // far out of range
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);        // drained, reports empty
    send_command(CMD_CLEAR, 64'h0, 16'h0, 12'd0);
    send_command(CMD_PUT,  64'h0123_4567_89AB_CDEF, 16'h8000, 12'd0);
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd2);        // slot invalidated by clear
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd0);

    // Register below the minimum acts as two slots: one record, then drops.
    write_ring_length(13'd0);
    send_command(CMD_PUT,  64'hFEDC_BA98_7654_3210, 16'h00FF, 12'd0);
    send_command(CMD_PUT,  64'h8000_0000_0000_0001, 16'h7FFF, 12'd0);
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd1);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);

    // All-ones register clamps to the full store.
    write_ring_length(13'h1FFF);
    send_command(CMD_PUT,  64'h0000_0000_FFFF_FFFF, 16'h1234, 12'd0);
    send_command(CMD_PEEK, 64'h0, 16'h0, 12'd2);
    send_command(CMD_GET,  64'h0, 16'h0, 12'd0);

    // Random phases: a new ring length each, idling switched per phase so
    // some stretches run at full rate on one or both sides.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      len_val = (phase < PHASE_COUNT) ? PHASE_LENS[phase] : 13'($urandom_range(2, 48));
      write_ring_length(len_val);
      tx_jitter = (phase % 3) != 1;
      rx_jitter = (phase % 4) != 2;
      quota = (tracker.ring_len() > 64) ? 40 : $urandom_range(70, 110);
      if (quota > RANDOM_ITEMS - sent) quota = RANDOM_ITEMS - sent;
      repeat (quota) begin
        send_random_item();
        sent++;
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
      phase++;
    end

    // Let the pipeline empty, then keep clocking so stray beats can still show up.
    wait_drained();
    repeat (10) @(posedge clk);
    tracker.settle();

    $display("Covered %0d commands over %0d ring lengths: %0d drops, %0d empty replies,",
             tracker.commands, phase + 3, tracker.drops, tracker.empty_replies);
    $display("%0d out-of-range peeks, %0d peeks of invalid slots, %0d clears; %0d mismatches",
             tracker.range_replies, tracker.dead_peeks, tracker.clears, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/orf_pkg.sv
hdl/orf_mem.sv
hdl/orf_ctrl.sv
hdl/overwriting_ring_fifo.sv
hdl/orf_checker.sv
tb/tb_overwriting_ring_fifo.sv
